// ===== sv/sld_pkg.sv =====
// Shared types and constants for the sync/length/xor deframer.
// Used by sld_core, sld_out_reg, the top level and the bench; depends on nothing.
package sld_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'h55;

  // frame level phase
  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_SYNC2   = 3'd1,
    PH_LEN     = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CHECK   = 3'd4
  } frame_phase_t;

  // sub-payload phase inside the frame payload
  typedef enum logic [1:0] {
    SP_TYPE = 2'd0,
    SP_LEN  = 2'd1,
    SP_DATA = 2'd2
  } sub_phase_t;

  // result word kinds
  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_OK      = 2'd1,
    KIND_CSUM    = 2'd2,
    KIND_OVERRUN = 2'd3
  } item_kind_t;

  // one result word
  typedef struct packed {
    item_kind_t  item_kind;
    logic [7:0]  data_value;
    logic [7:0]  sub_kind;
    logic [7:0]  sub_offset;
    logic        sub_last;
  } result_t;

endpackage

// ===== sv/sld_in_reg.sv =====
// Input register of the deframer: holds one received byte until the core takes it.
// Self-contained; depends on no other file.
module sld_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       take,
  output logic       hold_valid,
  output logic [7:0] hold_byte
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       load;

  // accept a new word when empty or when the held word leaves this cycle
  assign in_ready = !valid_r || take;
  assign load     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_rx_byte;
    end
  end

  assign hold_valid = valid_r;
  assign hold_byte  = byte_r;

endmodule

// ===== sv/sld_core.sv =====
// Deframer state and the single-pass step logic for one received byte.
// Depends on sld_pkg for phase enums, kinds and the result struct.
module sld_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [7:0]        rx_byte,
  output logic              res_valid,
  output sld_pkg::result_t  res
);

  sld_pkg::frame_phase_t phase_r, phase_nxt;
  sld_pkg::sub_phase_t   sub_phase_r, sub_phase_nxt;
  logic [7:0] frame_rem_r, frame_rem_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic [7:0] sub_kind_r, sub_kind_nxt;
  logic [7:0] sub_rem_r, sub_rem_nxt;
  logic [7:0] sub_pos_r, sub_pos_nxt;
  logic       overrun_r, overrun_nxt;

  logic [7:0] frame_dec;
  logic [7:0] sub_dec;
  logic [7:0] check_x;

  assign frame_dec = frame_rem_r - 8'd1;
  assign sub_dec   = sub_rem_r - 8'd1;
  assign check_x   = xor_r ^ rx_byte;

  // next state for the byte at hand
  always_comb begin
    phase_nxt     = phase_r;
    sub_phase_nxt = sub_phase_r;
    frame_rem_nxt = frame_rem_r;
    xor_nxt       = xor_r;
    sub_kind_nxt  = sub_kind_r;
    sub_rem_nxt   = sub_rem_r;
    sub_pos_nxt   = sub_pos_r;
    overrun_nxt   = overrun_r;

    unique case (phase_r)
      sld_pkg::PH_SYNC2: begin
        phase_nxt = (rx_byte == sld_pkg::SYNC_SECOND) ? sld_pkg::PH_LEN : sld_pkg::PH_HUNT;
      end
      sld_pkg::PH_LEN: begin
        frame_rem_nxt = rx_byte;
        xor_nxt       = rx_byte;
        sub_phase_nxt = sld_pkg::SP_TYPE;
        sub_kind_nxt  = 8'd0;
        sub_rem_nxt   = 8'd0;
        sub_pos_nxt   = 8'd0;
        overrun_nxt   = 1'b0;
        phase_nxt     = (rx_byte == 8'd0) ? sld_pkg::PH_CHECK : sld_pkg::PH_PAYLOAD;
      end
      sld_pkg::PH_PAYLOAD: begin
        xor_nxt       = check_x;
        frame_rem_nxt = frame_dec;
        unique case (sub_phase_r)
          sld_pkg::SP_TYPE: begin
            sub_kind_nxt  = rx_byte;
            sub_phase_nxt = sld_pkg::SP_LEN;
          end
          sld_pkg::SP_LEN: begin
            sub_rem_nxt = rx_byte;
            sub_pos_nxt = 8'd0;
            if (rx_byte > frame_dec) begin
              overrun_nxt = 1'b1;
            end
            sub_phase_nxt = (rx_byte == 8'd0) ? sld_pkg::SP_TYPE : sld_pkg::SP_DATA;
          end
          default: begin
            // data byte advances the sub-payload position
            sub_pos_nxt = sub_pos_r + 8'd1;
            sub_rem_nxt = sub_dec;
            if (sub_dec == 8'd0) begin
              sub_phase_nxt = sld_pkg::SP_TYPE;
            end
          end
        endcase
        if (frame_dec == 8'd0) begin
          phase_nxt = sld_pkg::PH_CHECK;
        end
      end
      sld_pkg::PH_CHECK: begin
        xor_nxt   = check_x;
        phase_nxt = sld_pkg::PH_HUNT;
      end
      default: begin
        phase_nxt = (rx_byte == sld_pkg::SYNC_FIRST) ? sld_pkg::PH_SYNC2 : sld_pkg::PH_HUNT;
      end
    endcase
  end

  // result word for the byte at hand
  always_comb begin
    res_valid     = 1'b0;
    res           = '0;
    res.item_kind = sld_pkg::KIND_DATA;

    unique case (phase_r)
      sld_pkg::PH_PAYLOAD: begin
        // data byte goes straight out, tagged
        if (sub_phase_r != sld_pkg::SP_TYPE && sub_phase_r != sld_pkg::SP_LEN) begin
          res_valid      = 1'b1;
          res.item_kind  = sld_pkg::KIND_DATA;
          res.data_value = rx_byte;
          res.sub_kind   = sub_kind_r;
          res.sub_offset = sub_pos_r;
          res.sub_last   = (sub_rem_r == 8'd1);
        end
      end
      sld_pkg::PH_CHECK: begin
        // checksum error wins over overrun
        res_valid = 1'b1;
        if (check_x != 8'd0) begin
          res.item_kind = sld_pkg::KIND_CSUM;
        end else if (overrun_r || sub_phase_r == sld_pkg::SP_LEN) begin
          res.item_kind = sld_pkg::KIND_OVERRUN;
        end else begin
          res.item_kind = sld_pkg::KIND_OK;
        end
      end
      default: begin
      end
    endcase
  end

  // state registers advance only when a byte is consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= sld_pkg::PH_HUNT;
      sub_phase_r <= sld_pkg::SP_TYPE;
      frame_rem_r <= 8'd0;
      xor_r       <= 8'd0;
      sub_kind_r  <= 8'd0;
      sub_rem_r   <= 8'd0;
      sub_pos_r   <= 8'd0;
      overrun_r   <= 1'b0;
    end else if (fire) begin
      phase_r     <= phase_nxt;
      sub_phase_r <= sub_phase_nxt;
      frame_rem_r <= frame_rem_nxt;
      xor_r       <= xor_nxt;
      sub_kind_r  <= sub_kind_nxt;
      sub_rem_r   <= sub_rem_nxt;
      sub_pos_r   <= sub_pos_nxt;
      overrun_r   <= overrun_nxt;
    end
  end

  // payload phase always has bytes still due
  a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == sld_pkg::PH_PAYLOAD |-> frame_rem_r != 8'd0)
    else $error("payload phase with zero bytes remaining");

  // a length byte seeds the running xor with itself
  a_len_seeds_xor: assert property (@(posedge clk) disable iff (!rst_n)
    fire && phase_r == sld_pkg::PH_LEN |=> xor_r == frame_rem_r)
    else $error("running xor not seeded by length");

  // the checksum byte always closes the frame
  a_check_closes: assert property (@(posedge clk) disable iff (!rst_n)
    fire && phase_r == sld_pkg::PH_CHECK |=> phase_r == sld_pkg::PH_HUNT)
    else $error("frame not closed after checksum");

endmodule

// ===== sv/sld_out_reg.sv =====
// Result register of the deframer: holds one result word until the consumer takes it.
// Depends on sld_pkg for the result struct.
module sld_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic              load_valid,
  input  sld_pkg::result_t  load_res,
  input  logic              out_ready,
  output logic              out_valid,
  output sld_pkg::result_t  out_res
);

  logic             valid_r, valid_nxt;
  sld_pkg::result_t res_r;

  // a load replaces the word; otherwise a taken word leaves
  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = load_valid;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_valid) begin
      res_r <= load_res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ===== sv/sync_length_xor_deframer.sv =====
// Sync/length/xor-checksum serial deframer, top level.
// Instantiates sld_in_reg, sld_core and sld_out_reg; uses sld_pkg.
//
// Takes one received byte per accepted word and sustains one byte per clock
// while the output is not stalled: an accepted byte is held in the input
// register and the step logic moves it into the result register at the next
// edge at which that register is free. The frame is hunted by the sync pair
// 0xAA 0x55, followed by a length byte, that many payload bytes and an xor
// checksum byte. Payload data bytes are passed out at once, tagged with
// sub-payload type, offset and last mark; one status word (ok, checksum
// error, overrun) closes each frame. Nothing is buffered: discard a frame's
// data when its status word reports an error. Stalls on the output back up
// into the input.
module sync_length_xor_deframer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_item_kind,
  output logic [7:0] out_data_value,
  output logic [7:0] out_sub_kind,
  output logic [7:0] out_sub_offset,
  output logic       out_sub_last
);

  logic             hold_valid;
  logic [7:0]       hold_byte;
  logic             fire;
  logic             res_valid;
  sld_pkg::result_t res;
  sld_pkg::result_t out_res;

  // consume the held byte when the result register is free or draining
  assign fire = hold_valid && (!out_valid || out_ready);

  sld_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .take       (fire),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte)
  );

  sld_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .rx_byte   (hold_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  sld_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire),
    .load_valid (res_valid),
    .load_res   (res),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_res    (out_res)
  );

  // result word onto its ports
  assign out_item_kind  = out_res.item_kind;
  assign out_data_value = out_res.data_value;
  assign out_sub_kind   = out_res.sub_kind;
  assign out_sub_offset = out_res.sub_offset;
  assign out_sub_last   = out_res.sub_last;

endmodule

// ===== test/tb.sv =====
// Self-checking bench for sync_length_xor_deframer: byte stream in, tagged words out.
// Depends on sld_pkg and the deframer RTL; predicts each word from its own model.
`timescale 1ns / 100ps

module tb;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_item_kind;
  logic [7:0] out_data_value;
  logic [7:0] out_sub_kind;
  logic [7:0] out_sub_offset;
  logic       out_sub_last;

  // bytes waiting to be driven and words the deframer owes us
  logic [7:0]       rx_stream [$];
  sld_pkg::result_t owed_words [$];
  int         pushed = 0;
  int         fail_count = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  logic       in_accepted = 1'b0;
  logic       holding_off = 1'b0;
  event       hold_off_ev;

  // predictor state
  sld_pkg::frame_phase_t fr_phase = sld_pkg::PH_HUNT;
  sld_pkg::sub_phase_t   sb_phase = sld_pkg::SP_TYPE;
  logic [7:0]   fr_left = '0;
  logic [7:0]   fr_xor = '0;
  logic [7:0]   sb_kind = '0;
  logic [7:0]   sb_left = '0;
  logic [7:0]   sb_pos = '0;
  logic         sb_overrun = 1'b0;

  sync_length_xor_deframer u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_item_kind (out_item_kind),
    .out_data_value(out_data_value),
    .out_sub_kind  (out_sub_kind),
    .out_sub_offset(out_sub_offset),
    .out_sub_last  (out_sub_last)
  );

  always #2 clk = ~clk;

  // advance the deframer model by one byte, queue the word it owes
  function automatic void deframe_step(input logic [7:0] b);
    logic [7:0]       x;
    sld_pkg::result_t w;
    w = '0;
    case (fr_phase)
      sld_pkg::PH_SYNC2: begin
        fr_phase = (b == sld_pkg::SYNC_SECOND) ? sld_pkg::PH_LEN : sld_pkg::PH_HUNT;
      end
      sld_pkg::PH_LEN: begin
        fr_left    = b;
        fr_xor     = b;
        sb_phase   = sld_pkg::SP_TYPE;
        sb_kind    = '0;
        sb_left    = '0;
        sb_pos     = '0;
        sb_overrun = 1'b0;
        fr_phase   = (b == 8'd0) ? sld_pkg::PH_CHECK : sld_pkg::PH_PAYLOAD;
      end
      sld_pkg::PH_PAYLOAD: begin
        fr_xor  = fr_xor ^ b;
        fr_left = fr_left - 8'd1;
        if (sb_phase == sld_pkg::SP_TYPE) begin
          sb_kind  = b;
          sb_phase = sld_pkg::SP_LEN;
        end else if (sb_phase == sld_pkg::SP_LEN) begin
          sb_left = b;
          sb_pos  = '0;
          if (b > fr_left) sb_overrun = 1'b1;
          sb_phase = (b == 8'd0) ? sld_pkg::SP_TYPE : sld_pkg::SP_DATA;
        end else begin
          w.item_kind  = sld_pkg::KIND_DATA;
          w.data_value = b;
          w.sub_kind   = sb_kind;
          w.sub_offset = sb_pos;
          w.sub_last   = (sb_left == 8'd1);
          owed_words.push_back(w);
          sb_pos  = sb_pos + 8'd1;
          sb_left = sb_left - 8'd1;
          if (sb_left == 8'd0) sb_phase = sld_pkg::SP_TYPE;
        end
        if (fr_left == 8'd0) fr_phase = sld_pkg::PH_CHECK;
      end
      sld_pkg::PH_CHECK: begin
        x = fr_xor ^ b;
        fr_xor = x;
        if (x != 8'd0) w.item_kind = sld_pkg::KIND_CSUM;
        else if (sb_overrun || sb_phase == sld_pkg::SP_LEN) w.item_kind = sld_pkg::KIND_OVERRUN;
        else w.item_kind = sld_pkg::KIND_OK;
        owed_words.push_back(w);
        fr_phase = sld_pkg::PH_HUNT;
      end
      default: begin
        fr_phase = (b == sld_pkg::SYNC_FIRST) ? sld_pkg::PH_SYNC2 : sld_pkg::PH_HUNT;
      end
    endcase
  endfunction

  task automatic put_byte(input logic [7:0] b);
    rx_stream.push_back(b);
    pushed++;
  endtask

  // one frame of random sub-payloads, sometimes cut short, padded or with a bad checksum
  task automatic queue_frame();
    logic [7:0] body [$];
    logic [7:0] cks;
    int subs;
    int len;
    int room;
    int flen;
    int pick;
    subs = $urandom_range(0, 3);
    for (int s = 0; s < subs; s++) begin
      room = 255 - body.size() - 2;
      if (room < 0) break;
      len = ($urandom_range(0, 29) == 0) ? $urandom_range(0, 253) : $urandom_range(0, 5);
      if (len > room) len = room;
      body.push_back(8'($urandom_range(0, 255)));
      body.push_back(len[7:0]);
      for (int i = 0; i < len; i++) body.push_back(8'($urandom_range(0, 255)));
    end
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      flen = body.size();
    end else if (pick < 9) begin
      flen = $urandom_range(0, body.size());
    end else begin
      len = $urandom_range(1, 3);
      for (int i = 0; i < len && body.size() < 255; i++) begin
        body.push_back(8'($urandom_range(0, 255)));
      end
      flen = body.size();
    end
    cks = flen[7:0];
    for (int i = 0; i < flen; i++) cks = cks ^ body[i];
    if ($urandom_range(0, 6) == 0) cks = cks ^ 8'($urandom_range(1, 255));
    put_byte(sld_pkg::SYNC_FIRST);
    put_byte(sld_pkg::SYNC_SECOND);
    put_byte(flen[7:0]);
    for (int i = 0; i < flen; i++) put_byte(body[i]);
    put_byte(cks);
  endtask

  // line noise and broken sync pairs between frames
  task automatic queue_noise();
    case ($urandom_range(0, 2))
      0: put_byte(8'($urandom_range(0, 255)));
      1: begin
        put_byte(sld_pkg::SYNC_FIRST);
        put_byte(8'($urandom_range(0, 255)));
      end
      default: begin
        put_byte(sld_pkg::SYNC_FIRST);
        put_byte(sld_pkg::SYNC_FIRST);
        put_byte(sld_pkg::SYNC_SECOND);
      end
    endcase
  endtask

  // wait until every byte is taken and every owed word has come out
  task automatic drain();
    while (rx_stream.size() != 0 || in_valid || owed_words.size() != 0) @(posedge clk);
  endtask

  // input driver: hold a word until taken, then maybe offer the next
  always @(negedge clk) begin : drive_bytes
    logic       nv;
    logic [7:0] nb;
    nv = in_valid;
    nb = in_rx_byte;
    if (!rst_n) begin
      nv = 1'b0;
    end else if (!in_valid || in_accepted) begin
      nv = 1'b0;
      if (rx_stream.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nv = 1'b1;
        nb = rx_stream.pop_front();
      end
    end
    in_valid   <= nv;
    in_rx_byte <= nb;
  end

  // receiver ready, with random stalls and the long hold-off
  always @(negedge clk) begin
    out_ready <= rst_n && !holding_off && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // long receiver hold-off, counted in its own process
  always @(hold_off_ev) begin
    holding_off <= 1'b1;
    repeat (300) @(negedge clk);
    holding_off <= 1'b0;
  end

  // monitor: feed accepted bytes to the model, check accepted words
  always @(posedge clk) begin : watch_words
    sld_pkg::result_t w;
    logic             bad;
    in_accepted = rst_n && in_valid && in_ready;
    if (in_accepted) deframe_step(in_rx_byte);
    if (rst_n && out_valid && out_ready) begin
      if (owed_words.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected word: kind %0d data %02h sub %02h off %0d last %0b",
                   out_item_kind, out_data_value, out_sub_kind, out_sub_offset, out_sub_last);
      end else begin
        w = owed_words.pop_front();
        bad = (out_item_kind !== w.item_kind) || (out_data_value !== w.data_value) ||
              (out_sub_kind !== w.sub_kind) || (out_sub_offset !== w.sub_offset) ||
              (out_sub_last !== w.sub_last);
        if (bad) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch: exp kind %0d data %02h sub %02h off %0d last %0b",
                     w.item_kind, w.data_value, w.sub_kind, w.sub_offset, w.sub_last);
            $display("          got kind %0d data %02h sub %02h off %0d last %0b",
                     out_item_kind, out_data_value, out_sub_kind, out_sub_offset,
                     out_sub_last);
          end
        end
      end
    end
  end

  // stimulus sequence
  initial begin : run_stimulus
    logic [7:0] dir_bytes [$];
    int phase_send [4];
    int phase_recv [4];
    int start;
    phase_send = '{0, 82, 0, 9};
    phase_recv = '{0, 0, 82, 9};
    // bad second sync (second 0xAA is not a fresh start), zero-length frame with
    // bad checksum, zero-length sub-payload with extreme bytes, sub-payload
    // overrunning the frame, type with no length plus bad checksum
    dir_bytes = '{sld_pkg::SYNC_FIRST, sld_pkg::SYNC_FIRST, sld_pkg::SYNC_SECOND,
                  sld_pkg::SYNC_FIRST, sld_pkg::SYNC_SECOND, 8'h00, 8'h01,
                  sld_pkg::SYNC_FIRST, sld_pkg::SYNC_SECOND, 8'h06, 8'hFF, 8'h02,
                  8'hFF, 8'h00, 8'h07, 8'h00, 8'h03,
                  sld_pkg::SYNC_FIRST, sld_pkg::SYNC_SECOND, 8'h02, 8'h01, 8'h05, 8'h06,
                  sld_pkg::SYNC_FIRST, sld_pkg::SYNC_SECOND, 8'h01, 8'h09, 8'h00};
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames
    foreach (dir_bytes[i]) put_byte(dir_bytes[i]);
    drain();

    // random frames under each idling mix
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = phase_send[p];
      recv_stall_pct = phase_recv[p];
      start = pushed;
      while (pushed - start < 300) begin
        if ($urandom_range(0, 4) != 0) queue_frame();
        else queue_noise();
      end
      // block the receiver while the sender keeps offering
      if (p == 0) -> hold_off_ev;
      drain();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // run time limit
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
sv/sld_pkg.sv
sv/sld_in_reg.sv
sv/sld_core.sv
sv/sld_out_reg.sv
sv/sync_length_xor_deframer.sv
test/tb.sv
